[rtl/itc_pkg.sv]
// ----------------------------------------------------------------------------
// itc_pkg: shared definitions for the IoU track table counter
// Default sizes, register map, reset values and the command and status
// bundles that join the controller to the datapath.
// ----------------------------------------------------------------------------
package itc_pkg;

  // Default sizes
  localparam int TRACK_SLOTS_DEF = 64;
  localparam int COORD_BITS_DEF  = 12;

  // Fixed field widths
  localparam int SCORE_BITS = 10;
  localparam int TOTAL_BITS = 32;

  // Register port
  localparam int CFG_DW = 32;
  localparam int CFG_AW = 3;

  // Register index, taken from paddr[2]
  localparam logic REG_MIN_SCORE = 1'b0;

  // Reset value of the score threshold (about 0.9 in units of 1/1024)
  localparam logic [SCORE_BITS-1:0] MIN_SCORE_RST = 10'd922;

  // Controller to datapath
  typedef struct packed {
    logic capture;     // latch the accepted item
    logic clear_occ;   // drop all tracks
    logic scan_start;  // start the overlap scan over the stored tracks
    logic append;      // count the box as new and store it if there is room
    logic out_load;    // load the result register
  } itc_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic clr_cmd;     // item is a clear command
    logic first;       // first box of its frame
    logic last;        // last box of its frame
    logic pass;        // score reaches the threshold
    logic occ_zero;    // no stored tracks
    logic scan_done;   // scan finished and pipeline drained
    logic matched;     // scan overwrote at least one track
    logic out_busy;    // result register holds an untaken result
  } itc_stat_t;

endpackage

[rtl/itc_datapath.sv]
// ----------------------------------------------------------------------------
// itc_datapath: track memory, overlap pipeline and counters
// Holds the accepted item, scans the stored tracks through a three stage
// overlap pipeline, keeps occupancy and the vehicle total, and drives the
// result register.
// ----------------------------------------------------------------------------
module itc_datapath #(
  parameter int TRACK_SLOTS = itc_pkg::TRACK_SLOTS_DEF,
  parameter int COORD_BITS  = itc_pkg::COORD_BITS_DEF,
  localparam int CW = $clog2(TRACK_SLOTS + 1)
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  itc_pkg::itc_cmd_t               cmd,
  output itc_pkg::itc_stat_t              stat,
  input  logic [itc_pkg::SCORE_BITS-1:0]  min_score,
  // Item payload
  input  logic                            in_cmd,
  input  logic                            in_first_in_frame,
  input  logic                            in_last_in_frame,
  input  logic [itc_pkg::SCORE_BITS-1:0]  in_score,
  input  logic [COORD_BITS-1:0]           in_x_left,
  input  logic [COORD_BITS-1:0]           in_y_top,
  input  logic [COORD_BITS-1:0]           in_x_right,
  input  logic [COORD_BITS-1:0]           in_y_bottom,
  // Result channel
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic                            out_is_new,
  output logic [itc_pkg::TOTAL_BITS-1:0]  out_total_count,
  output logic                            out_table_full,
  output logic [CW-1:0]                   out_tracks_in_use
);
  import itc_pkg::*;

  localparam int IW  = $clog2(TRACK_SLOTS);
  localparam int BW  = 4 * COORD_BITS;      // packed box
  localparam int DW  = COORD_BITS + 1;      // signed side length
  localparam int SW  = COORD_BITS + 3;      // signed overlap side
  localparam int MW  = SW - 1;              // overlap side once known positive
  localparam int PW  = 2 * MW;              // intersection area
  localparam int AW  = 2 * DW;              // signed box area
  localparam int CMW = 2 * COORD_BITS + 7;  // compare width

  // Accepted item
  logic                  cmd_r, first_r, last_r;
  logic [SCORE_BITS-1:0] score_r;
  logic [COORD_BITS-1:0] bx0_r, by0_r, bx1_r, by1_r;

  // Counters and per item flags
  logic [CW-1:0]         occ_r, occ_nxt;
  logic [TOTAL_BITS-1:0] total_r, total_nxt;
  logic                  new_r, full_r;
  logic                  occ_full;

  // Scan control
  logic          scan_act_r;
  logic [CW-1:0] rd_idx_r, rd_idx_nxt;
  logic          issue;
  logic          matched_r;

  // Pipeline
  logic [BW-1:0]        rd_data_r;
  logic                 s1_vld_r, s2_vld_r, s3_vld_r;
  logic [IW-1:0]        s1_idx_r, s2_idx_r, s3_idx_r;
  logic [MW-1:0]        s2_ix_r, s2_iy_r;
  logic signed [DW-1:0] s2_tw_r, s2_th_r;
  logic                 s2_ovl_r, s3_ovl_r;
  logic [PW-1:0]        s3_inter_r;
  logic signed [AW-1:0] s3_area_b_r, area_a_r;

  // Memory write port
  logic          mem_we;
  logic [IW-1:0] mem_wa;
  logic [BW-1:0] box_w;
  logic [BW-1:0] trk_mem [TRACK_SLOTS];

  // Result register
  logic                  out_valid_r, out_is_new_r, out_full_r;
  logic [TOTAL_BITS-1:0] out_total_r;
  logic [CW-1:0]         out_tracks_r;

  // Stage 1 terms
  logic [COORD_BITS-1:0] tx0, ty0, tx1, ty1;
  logic [COORD_BITS-1:0] xmin, ymin, xmax, ymax;
  logic signed [DW-1:0]  bw, bh, tw, th, spx, spy;
  logic signed [SW-1:0]  sw, sh, ix, iy;
  logic                  ovl;

  // Stage 3 terms
  logic [CMW-1:0]        tri_inter;
  logic signed [CMW-1:0] area_sum;
  logic                  match;

  // Capture the accepted item
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      cmd_r   <= in_cmd;
      first_r <= in_first_in_frame;
      last_r  <= in_last_in_frame;
      score_r <= in_score;
      bx0_r   <= in_x_left;
      by0_r   <= in_y_top;
      bx1_r   <= in_x_right;
      by1_r   <= in_y_bottom;
    end
  end

  // Box sides and area, settled long before the first compare needs them
  assign bw = $signed({1'b0, bx1_r}) - $signed({1'b0, bx0_r});
  assign bh = $signed({1'b0, by1_r}) - $signed({1'b0, by0_r});

  always_ff @(posedge clk) begin
    area_a_r <= bw * bh;
  end

  assign box_w = {bx0_r, by0_r, bx1_r, by1_r};

  // Track memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      trk_mem[mem_wa] <= box_w;
    end
    rd_data_r <= trk_mem[rd_idx_r[IW-1:0]];
  end

  // Issue one read per cycle while entries remain
  assign issue      = scan_act_r && (rd_idx_r < occ_r);
  assign rd_idx_nxt = cmd.scan_start ? '0 :
                      issue          ? CW'(rd_idx_r + 1'b1) : rd_idx_r;

  // Stage 1: spans and overlap sides of the box against the read track
  assign tx0 = rd_data_r[BW-1 -: COORD_BITS];
  assign ty0 = rd_data_r[BW-COORD_BITS-1 -: COORD_BITS];
  assign tx1 = rd_data_r[2*COORD_BITS-1 -: COORD_BITS];
  assign ty1 = rd_data_r[COORD_BITS-1:0];

  assign xmin = (bx0_r < tx0) ? bx0_r : tx0;
  assign ymin = (by0_r < ty0) ? by0_r : ty0;
  assign xmax = (bx1_r > tx1) ? bx1_r : tx1;
  assign ymax = (by1_r > ty1) ? by1_r : ty1;

  assign tw  = $signed({1'b0, tx1}) - $signed({1'b0, tx0});
  assign th  = $signed({1'b0, ty1}) - $signed({1'b0, ty0});
  assign spx = $signed({1'b0, xmax}) - $signed({1'b0, xmin});
  assign spy = $signed({1'b0, ymax}) - $signed({1'b0, ymin});
  assign sw  = SW'(bw) + SW'(tw);
  assign sh  = SW'(bh) + SW'(th);
  assign ix  = sw - SW'(spx);
  assign iy  = sh - SW'(spy);

  // Touching or inverted overlap counts as none
  assign ovl = !ix[SW-1] && (ix != '0) && !iy[SW-1] && (iy != '0);

  always_ff @(posedge clk) begin
    s2_ix_r  <= ix[MW-1:0];
    s2_iy_r  <= iy[MW-1:0];
    s2_tw_r  <= tw;
    s2_th_r  <= th;
    s2_ovl_r <= ovl;
    s2_idx_r <= s1_idx_r;
    s1_idx_r <= rd_idx_r[IW-1:0];
  end

  // Stage 2: intersection and track area
  always_ff @(posedge clk) begin
    s3_inter_r  <= s2_ix_r * s2_iy_r;
    s3_area_b_r <= s2_tw_r * s2_th_r;
    s3_ovl_r    <= s2_ovl_r;
    s3_idx_r    <= s2_idx_r;
  end

  // Stage 3: 2*inter > union, i.e. 3*inter > areaA + areaB
  assign tri_inter = CMW'(s3_inter_r) + CMW'({s3_inter_r, 1'b0});
  assign area_sum  = CMW'(area_a_r) + CMW'(s3_area_b_r);
  assign match     = s3_vld_r && s3_ovl_r && ($signed(tri_inter) > area_sum);

  // Overwrite matched tracks during the scan, append afterwards
  assign occ_full = (occ_r == CW'(TRACK_SLOTS));
  assign mem_we   = match || (cmd.append && !occ_full);
  assign mem_wa   = match ? s3_idx_r : occ_r[IW-1:0];

  // Occupancy and saturating total
  always_comb begin
    occ_nxt   = occ_r;
    total_nxt = total_r;
    if (cmd.clear_occ) begin
      occ_nxt = '0;
    end else if (cmd.append && !occ_full) begin
      occ_nxt = CW'(occ_r + 1'b1);
    end
    if (cmd.append && (total_r != '1)) begin
      total_nxt = total_r + 1'b1;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r       <= '0;
      total_r     <= '0;
      scan_act_r  <= 1'b0;
      rd_idx_r    <= '0;
      matched_r   <= 1'b0;
      s1_vld_r    <= 1'b0;
      s2_vld_r    <= 1'b0;
      s3_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      occ_r       <= occ_nxt;
      total_r     <= total_nxt;
      scan_act_r  <= cmd.scan_start || issue;
      rd_idx_r    <= rd_idx_nxt;
      matched_r   <= !cmd.scan_start && (matched_r || match);
      s1_vld_r    <= issue;
      s2_vld_r    <= s1_vld_r;
      s3_vld_r    <= s2_vld_r;
      out_valid_r <= cmd.out_load || (out_valid_r && out_stall);
    end
  end

  // Per item result flags
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      new_r  <= 1'b0;
      full_r <= 1'b0;
    end else if (cmd.append) begin
      new_r  <= 1'b1;
      full_r <= occ_full;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_is_new_r <= new_r;
      out_full_r   <= full_r;
      out_total_r  <= total_r;
      out_tracks_r <= occ_r;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_is_new        = out_is_new_r;
  assign out_total_count   = out_total_r;
  assign out_table_full    = out_full_r;
  assign out_tracks_in_use = out_tracks_r;

  // Status to the controller
  assign stat.clr_cmd   = cmd_r;
  assign stat.first     = first_r;
  assign stat.last      = last_r;
  assign stat.pass      = (score_r >= min_score);
  assign stat.occ_zero  = (occ_r == '0);
  assign stat.scan_done = !scan_act_r && !s1_vld_r && !s2_vld_r && !s3_vld_r;
  assign stat.matched   = matched_r;
  assign stat.out_busy  = out_valid_r && out_stall;

endmodule

[rtl/itc_ctrl.sv]
// ----------------------------------------------------------------------------
// itc_ctrl: item sequencer for the IoU track table counter
// Steps each item through evaluate, scan, append and result hand-off, and
// keeps the per frame flags.
// ----------------------------------------------------------------------------
module itc_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  itc_pkg::itc_stat_t  stat,
  output itc_pkg::itc_cmd_t   cmd
);
  import itc_pkg::*;

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_EVAL   = 5'b00010,
    ST_SCAN   = 5'b00100,
    ST_APPEND = 5'b01000,
    ST_FINISH = 5'b10000
  } itc_state_t;

  itc_state_t state_r, state_nxt;
  logic       bypass_r, bypass_nxt;
  logic       had_r, had_nxt;
  logic       byp_eff, had_eff;

  // Frame flags as seen by this box
  assign byp_eff = stat.first ? stat.occ_zero : bypass_r;
  assign had_eff = stat.first ? 1'b0 : had_r;

  assign in_stall = (state_r != ST_IDLE);

  always_comb begin
    state_nxt  = state_r;
    bypass_nxt = bypass_r;
    had_nxt    = had_r;
    cmd        = '0;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = ST_EVAL;
        end
      end
      ST_EVAL: begin
        if (stat.clr_cmd) begin
          // Clear command keeps the frame flags
          cmd.clear_occ = 1'b1;
          state_nxt     = ST_FINISH;
        end else begin
          bypass_nxt = byp_eff;
          had_nxt    = had_eff || stat.pass;
          if (!stat.pass) begin
            // Drop the box; an empty frame ends by dropping all tracks
            cmd.clear_occ = stat.last && !had_eff;
            state_nxt     = ST_FINISH;
          end else if (byp_eff || stat.occ_zero) begin
            state_nxt = ST_APPEND;
          end else begin
            cmd.scan_start = 1'b1;
            state_nxt      = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        if (stat.scan_done) begin
          state_nxt = stat.matched ? ST_FINISH : ST_APPEND;
        end
      end
      ST_APPEND: begin
        cmd.append = 1'b1;
        state_nxt  = ST_FINISH;
      end
      ST_FINISH: begin
        // Hold until the result register is free
        if (!stat.out_busy) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      bypass_r <= 1'b0;
      had_r    <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      bypass_r <= bypass_nxt;
      had_r    <= had_nxt;
    end
  end

endmodule

[rtl/iou_track_table_counter.sv]
// ----------------------------------------------------------------------------
// iou_track_table_counter: IoU greedy tracker with vehicle counter
// Sequence: a clear command or a dropped box goes from evaluate to the result
//   load; a box appended without a scan passes through append first; a scanned
//   box scans every stored track, then loads if it matched, else appends first.
// Throughput: one item at a time; the input reopens the cycle after the result
//   is loaded, and stays closed while a result waits in the result register.
// Reset: synchronous, active low; empties the table, zeroes the total and
//   frame flags and sets min_score to 922. No clearing pass is needed.
// ----------------------------------------------------------------------------
module iou_track_table_counter #(
  parameter int TRACK_SLOTS = itc_pkg::TRACK_SLOTS_DEF,
  parameter int COORD_BITS  = itc_pkg::COORD_BITS_DEF,
  localparam int CW = $clog2(TRACK_SLOTS + 1)
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // Register port
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [itc_pkg::CFG_AW-1:0]      paddr,
  input  logic [itc_pkg::CFG_DW-1:0]      pwdata,
  output logic [itc_pkg::CFG_DW-1:0]      prdata,
  output logic                            pready,
  // Input channel
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic                            in_cmd,
  input  logic                            in_first_in_frame,
  input  logic                            in_last_in_frame,
  input  logic [itc_pkg::SCORE_BITS-1:0]  in_score,
  input  logic [COORD_BITS-1:0]           in_x_left,
  input  logic [COORD_BITS-1:0]           in_y_top,
  input  logic [COORD_BITS-1:0]           in_x_right,
  input  logic [COORD_BITS-1:0]           in_y_bottom,
  // Result channel
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic                            out_is_new,
  output logic [itc_pkg::TOTAL_BITS-1:0]  out_total_count,
  output logic                            out_table_full,
  output logic [CW-1:0]                   out_tracks_in_use
);
  import itc_pkg::*;

  logic [SCORE_BITS-1:0] min_score_r;
  logic                  cfg_wr;
  itc_cmd_t              cmd;
  itc_stat_t             stat;

  // Register port: no wait states
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_MIN_SCORE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_score_r <= MIN_SCORE_RST;
    end else if (cfg_wr) begin
      min_score_r <= pwdata[SCORE_BITS-1:0];
    end
  end

  assign prdata = (paddr[2] == REG_MIN_SCORE) ? CFG_DW'(min_score_r) : '0;

  itc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  itc_datapath #(
    .TRACK_SLOTS (TRACK_SLOTS),
    .COORD_BITS  (COORD_BITS)
  ) u_datapath (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .stat              (stat),
    .min_score         (min_score_r),
    .in_cmd            (in_cmd),
    .in_first_in_frame (in_first_in_frame),
    .in_last_in_frame  (in_last_in_frame),
    .in_score          (in_score),
    .in_x_left         (in_x_left),
    .in_y_top          (in_y_top),
    .in_x_right        (in_x_right),
    .in_y_bottom       (in_y_bottom),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_is_new        (out_is_new),
    .out_total_count   (out_total_count),
    .out_table_full    (out_table_full),
    .out_tracks_in_use (out_tracks_in_use)
  );

endmodule

[rtl/itc_checker.sv]
// ----------------------------------------------------------------------------
// itc_checker: port level checks for the IoU track table counter
// Watches the result channel for occupancy bounds, full table flag
// consistency, count progress between transfers and result hold.
// ----------------------------------------------------------------------------
module itc_checker #(
  parameter int TRACK_SLOTS = itc_pkg::TRACK_SLOTS_DEF,
  localparam int CW = $clog2(TRACK_SLOTS + 1)
) (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            out_valid,
  input logic                            out_stall,
  input logic                            out_is_new,
  input logic [itc_pkg::TOTAL_BITS-1:0]  out_total_count,
  input logic                            out_table_full,
  input logic [CW-1:0]                   out_tracks_in_use
);
  import itc_pkg::*;

  logic                  seen_r;
  logic [TOTAL_BITS-1:0] last_total_r;
  logic                  out_xfer;

  assign out_xfer = out_valid && !out_stall;

  // Track the total of the previous result transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_r       <= 1'b0;
      last_total_r <= '0;
    end else if (out_xfer) begin
      seen_r       <= 1'b1;
      last_total_r <= out_total_count;
    end
  end

  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_tracks_in_use <= CW'(TRACK_SLOTS)))
    else $error("track occupancy above table size");

  a_full_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_table_full |-> out_is_new && (out_tracks_in_use == CW'(TRACK_SLOTS)))
    else $error("table full reported without a new box on a full table");

  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    out_xfer && seen_r |->
      (out_total_count == TOTAL_BITS'(last_total_r + TOTAL_BITS'(out_is_new))) ||
      ((last_total_r == '1) && (out_total_count == '1)))
    else $error("vehicle total does not follow the new box flag");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_total_count) &&
      $stable(out_is_new) && $stable(out_tracks_in_use))
    else $error("stalled result changed");

endmodule

bind iou_track_table_counter itc_checker #(
  .TRACK_SLOTS (TRACK_SLOTS)
) u_itc_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .out_valid         (out_valid),
  .out_stall         (out_stall),
  .out_is_new        (out_is_new),
  .out_total_count   (out_total_count),
  .out_table_full    (out_table_full),
  .out_tracks_in_use (out_tracks_in_use)
);

[dv/tb.sv]
// ----------------------------------------------------------------------------
// tb: testbench for iou_track_table_counter
// Drives detection boxes and clear commands in frames through the input
// channel and mirrors the tracker in a behavioral model. Every result is
// compared field by field with the model's prediction. Covers directed
// corner cases, score thresholds, table overflow, back-pressure and long
// random frame sequences under several threshold settings.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import itc_pkg::*;

  localparam int SLOTS        = TRACK_SLOTS_DEF;
  localparam int CB           = COORD_BITS_DEF;
  localparam int OCC_BITS     = $clog2(SLOTS + 1);
  localparam int COORD_MAX    = (1 << CB) - 1;
  localparam int SCORE_MAX    = (1 << SCORE_BITS) - 1;
  localparam int IDLE_LIMIT   = 4000;
  localparam int DRAIN_CYCLES = SLOTS + 16;
  localparam int HOLD_CYCLES  = 400;
  localparam logic [CFG_AW-1:0] MIN_SCORE_ADDR = {REG_MIN_SCORE, 2'b00};

  typedef enum bit {CMD_BOX = 1'b0, CMD_CLEAR = 1'b1} item_cmd_t;
  typedef enum int {RX_FREE, RX_RANDOM, RX_PATTERN} rx_mode_t;

  typedef struct {
    item_cmd_t           cmd;
    bit                  first;
    bit                  last;
    bit [SCORE_BITS-1:0] score;
    bit [CB-1:0]         x0, y0, x1, y1;
  } det_item_t;

  typedef struct {
    int x0, y0, x1, y1;
  } track_t;

  typedef struct {
    bit                  is_new;
    bit [TOTAL_BITS-1:0] total;
    bit                  full;
    bit [OCC_BITS-1:0]   in_use;
  } count_t;

  // Clock and reset
  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  // Register port
  logic              psel    = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite  = 1'b0;
  logic [CFG_AW-1:0] paddr   = '0;
  logic [CFG_DW-1:0] pwdata  = '0;
  logic [CFG_DW-1:0] prdata;
  logic              pready;

  // Input channel
  logic                  in_valid          = 1'b0;
  logic                  in_stall;
  logic                  in_cmd            = 1'b0;
  logic                  in_first_in_frame = 1'b0;
  logic                  in_last_in_frame  = 1'b0;
  logic [SCORE_BITS-1:0] in_score          = '0;
  logic [CB-1:0]         in_x_left         = '0;
  logic [CB-1:0]         in_y_top          = '0;
  logic [CB-1:0]         in_x_right        = '0;
  logic [CB-1:0]         in_y_bottom       = '0;

  // Result channel
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic                  out_is_new;
  logic [TOTAL_BITS-1:0] out_total_count;
  logic                  out_table_full;
  logic [OCC_BITS-1:0]   out_tracks_in_use;

  // Tracker model state
  bit [SCORE_BITS-1:0] thr_q = MIN_SCORE_RST;
  track_t              tracks [SLOTS];
  int                  occ_q     = 0;
  bit                  bypass_q  = 1'b0;
  bit                  had_box_q = 1'b0;
  bit [TOTAL_BITS-1:0] total_q   = '0;
  count_t              pending_counts [$];

  // Traffic control and statistics
  int       burst_left  = 0;
  bit       gaps_off    = 1'b0;
  rx_mode_t rx_mode     = RX_FREE;
  int       hold_left   = 0;
  int       rx_phase    = 0;
  int       idle_cycles = 0;
  int       mismatches  = 0;
  int       n_sent      = 0;
  int       n_got       = 0;
  int       n_new       = 0;
  int       n_full      = 0;

  iou_track_table_counter dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .prdata            (prdata),
    .pready            (pready),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_cmd            (in_cmd),
    .in_first_in_frame (in_first_in_frame),
    .in_last_in_frame  (in_last_in_frame),
    .in_score          (in_score),
    .in_x_left         (in_x_left),
    .in_y_top          (in_y_top),
    .in_x_right        (in_x_right),
    .in_y_bottom       (in_y_bottom),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_is_new        (out_is_new),
    .out_total_count   (out_total_count),
    .out_table_full    (out_table_full),
    .out_tracks_in_use (out_tracks_in_use)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Tracker model
  // ---------------------------------------------------------------------------

  // IoU above one half, done as 2*inter > union on signed extents
  function automatic bit iou_above_half(track_t a, track_t b);
    longint xmin, ymin, xmax, ymax, ix, iy, inter, uni;
    xmin = (a.x0 < b.x0) ? a.x0 : b.x0;
    ymin = (a.y0 < b.y0) ? a.y0 : b.y0;
    xmax = (a.x1 > b.x1) ? a.x1 : b.x1;
    ymax = (a.y1 > b.y1) ? a.y1 : b.y1;
    ix = longint'(a.x1 - a.x0) + longint'(b.x1 - b.x0) - (xmax - xmin);
    iy = longint'(a.y1 - a.y0) + longint'(b.y1 - b.y0) - (ymax - ymin);
    if (ix <= 0 || iy <= 0) return 1'b0;
    inter = ix * iy;
    uni = longint'(a.x1 - a.x0) * longint'(a.y1 - a.y0)
        + longint'(b.x1 - b.x0) * longint'(b.y1 - b.y0) - inter;
    return 2 * inter > uni;
  endfunction

  // Advance the tracker by one transfer and return the count it reports
  function automatic count_t track_and_count(det_item_t it);
    count_t r;
    track_t b;
    bit     hit;
    r = '{default: 0};
    if (it.cmd == CMD_CLEAR) begin
      occ_q = 0;
    end else begin
      b = '{int'(it.x0), int'(it.y0), int'(it.x1), int'(it.y1)};
      if (it.first) begin
        bypass_q  = (occ_q == 0);
        had_box_q = 1'b0;
      end
      if (it.score >= thr_q) begin
        hit       = 1'b0;
        had_box_q = 1'b1;
        if (!bypass_q) begin
          for (int j = 0; j < occ_q; j++) begin
            if (iou_above_half(b, tracks[j])) begin
              tracks[j] = b;
              hit       = 1'b1;
            end
          end
        end
        if (!hit) begin
          r.is_new = 1'b1;
          n_new++;
          if (total_q != '1) total_q++;
          if (occ_q < SLOTS) begin
            tracks[occ_q] = b;
            occ_q++;
          end else begin
            r.full = 1'b1;
            n_full++;
          end
        end
      end
      // a frame that passed no box flushes the table
      if (it.last && !had_box_q) occ_q = 0;
    end
    r.total  = total_q;
    r.in_use = OCC_BITS'(occ_q);
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Item builders
  // ---------------------------------------------------------------------------

  function automatic det_item_t mk(item_cmd_t c, bit f, bit l, int s,
                                   int x0, int y0, int x1, int y1);
    det_item_t it;
    it.cmd   = c;
    it.first = f;
    it.last  = l;
    it.score = SCORE_BITS'(s);
    it.x0    = CB'(x0);
    it.y0    = CB'(y0);
    it.x1    = CB'(x1);
    it.y1    = CB'(y1);
    return it;
  endfunction

  function automatic int nudge(int v);
    int n;
    n = v + $urandom_range(0, 16) - 8;
    return (n < 0) ? 0 : (n > COORD_MAX) ? COORD_MAX : n;
  endfunction

  // Random box: half near a stored track, some fully random, the rest fresh
  function automatic det_item_t rand_box(bit first, bit last, bit pass);
    det_item_t it;
    int        w, h, j, x0, y0;
    it.cmd   = CMD_BOX;
    it.first = first;
    it.last  = last;
    if (pass || thr_q == 0) it.score = SCORE_BITS'($urandom_range(thr_q, SCORE_MAX));
    else                    it.score = SCORE_BITS'($urandom_range(0, thr_q - 1));
    if (occ_q > 0 && $urandom_range(0, 1) == 1) begin
      j     = $urandom_range(0, occ_q - 1);
      it.x0 = CB'(nudge(tracks[j].x0));
      it.y0 = CB'(nudge(tracks[j].y0));
      it.x1 = CB'(nudge(tracks[j].x1));
      it.y1 = CB'(nudge(tracks[j].y1));
    end else if ($urandom_range(0, 7) == 0) begin
      it.x0 = CB'($urandom_range(0, COORD_MAX));
      it.y0 = CB'($urandom_range(0, COORD_MAX));
      it.x1 = CB'($urandom_range(0, COORD_MAX));
      it.y1 = CB'($urandom_range(0, COORD_MAX));
    end else begin
      w     = $urandom_range(1, 400);
      h     = $urandom_range(1, 400);
      x0    = $urandom_range(0, COORD_MAX);
      y0    = $urandom_range(0, COORD_MAX);
      it.x0 = CB'(x0);
      it.y0 = CB'(y0);
      it.x1 = CB'((x0 + w > COORD_MAX) ? COORD_MAX : x0 + w);
      it.y1 = CB'((y0 + h > COORD_MAX) ? COORD_MAX : y0 + h);
    end
    return it;
  endfunction

  // ---------------------------------------------------------------------------
  // Shared driving tasks
  // ---------------------------------------------------------------------------

  // Offer one item in bursts with random gaps; hold it until the transfer
  task automatic send_box(det_item_t it);
    int gap;
    gap = 0;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      if (!gaps_off && $urandom_range(0, 2) != 0) gap = $urandom_range(1, 10);
    end
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_cmd            <= it.cmd;
    in_first_in_frame <= it.first;
    in_last_in_frame  <= it.last;
    in_score          <= it.score;
    in_x_left         <= it.x0;
    in_y_top          <= it.y0;
    in_x_right        <= it.x1;
    in_y_bottom       <= it.y1;
    in_valid          <= 1'b1;
    do @(posedge clk); while (in_stall);
    pending_counts.insert(pending_counts.size(), track_and_count(it));
    burst_left--;
    n_sent++;
  endtask

  task automatic rest_input();
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  // Stop offering and wait until every expected count has come back
  task automatic drain();
    rest_input();
    while (pending_counts.size() != 0) @(posedge clk);
  endtask

  task automatic note_mismatch(string what);
    mismatches++;
    if (mismatches <= 10) $display("%0t ns: mismatch: %s", $time, what);
  endtask

  // Write min_score while idle and read it back
  task automatic set_min_score(bit [SCORE_BITS-1:0] v);
    drain();
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= MIN_SCORE_ADDR;
    pwdata  <= CFG_DW'(v);
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    thr_q = v;
    @(negedge clk);
    pwrite  <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata[SCORE_BITS-1:0] !== v)
      note_mismatch($sformatf("min_score readback exp %0d got %0d",
                              v, prdata[SCORE_BITS-1:0]));
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Result checking, receiver stalls and watchdog
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin
    count_t want;
    if (rst_n && out_valid && !out_stall) begin
      n_got++;
      if (pending_counts.size() == 0) begin
        note_mismatch($sformatf("unexpected result new=%0d total=%0d full=%0d use=%0d",
                                out_is_new, out_total_count, out_table_full,
                                out_tracks_in_use));
      end else begin
        want = pending_counts.pop_front();
        if (out_is_new !== want.is_new || out_total_count !== want.total ||
            out_table_full !== want.full || out_tracks_in_use !== want.in_use)
          note_mismatch($sformatf(
            "exp new=%0d total=%0d full=%0d use=%0d, got new=%0d total=%0d full=%0d use=%0d",
            want.is_new, want.total, want.full, want.in_use,
            out_is_new, out_total_count, out_table_full, out_tracks_in_use));
      end
    end
  end

  // Stall the result side: a counted hold-off first, else the current pattern
  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else begin
      case (rx_mode)
        RX_FREE:   out_stall <= 1'b0;
        RX_RANDOM: out_stall <= ($urandom_range(0, 99) < 35);
        default: begin
          out_stall <= ((rx_phase % 11) >= 7);
          rx_phase++;
        end
      endcase
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (psel && penable)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("Timeout: no transfer for %0d cycles, %0d results outstanding",
               IDLE_LIMIT, pending_counts.size());
      $display("CHECKS FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Corner cases at the reset threshold of 922
  task automatic test_directed_cases();
    rx_mode = RX_RANDOM;
    // clear with a junk payload
    send_box(mk(CMD_CLEAR, 1, 1, SCORE_MAX, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX));
    // empty table at frame start: append without matching, even duplicates
    send_box(mk(CMD_BOX, 1, 0, SCORE_MAX, 0, 0, COORD_MAX, COORD_MAX));
    send_box(mk(CMD_BOX, 0, 0, 921, 0, 0, COORD_MAX, COORD_MAX));
    send_box(mk(CMD_BOX, 0, 1, 922, 0, 0, COORD_MAX, COORD_MAX));
    // identical box overwrites both tracks
    send_box(mk(CMD_BOX, 1, 0, 1000, 0, 0, COORD_MAX, COORD_MAX));
    send_box(mk(CMD_BOX, 0, 0, 1000, 100, 100, 200, 200));
    // touching edges do not overlap
    send_box(mk(CMD_BOX, 0, 0, 1000, 200, 100, 300, 200));
    // IoU of exactly one half is no match, just above is
    send_box(mk(CMD_BOX, 0, 0, 1000, 100, 100, 200, 150));
    send_box(mk(CMD_BOX, 0, 0, 1000, 100, 100, 200, 151));
    // inverted, degenerate and extreme boxes
    send_box(mk(CMD_BOX, 0, 0, 1000, 300, 300, 200, 200));
    send_box(mk(CMD_BOX, 0, 0, 1000, 500, 500, 500, 500));
    send_box(mk(CMD_BOX, 0, 0, 1000, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX));
    send_box(mk(CMD_BOX, 0, 0, 1000, 0, 0, 0, 0));
    send_box(mk(CMD_BOX, 0, 0, 1000, COORD_MAX, 0, 0, COORD_MAX));
    // low-score last box: the frame already passed one, keep the tracks
    send_box(mk(CMD_BOX, 0, 1, 0, 10, 10, 20, 20));
    // frame with no passing box flushes the table
    send_box(mk(CMD_BOX, 1, 1, 0, 10, 10, 20, 20));
    // box with no frame start uses the flags as they stand
    send_box(mk(CMD_BOX, 0, 0, SCORE_MAX, 40, 40, 90, 90));
    send_box(mk(CMD_BOX, 1, 0, SCORE_MAX, 41, 40, 90, 91));
    send_box(mk(CMD_BOX, 0, 0, SCORE_MAX, 1000, 1000, 1200, 1100));
    // clear keeps frame flags; single-box frame
    send_box(mk(CMD_CLEAR, 0, 0, 0, 0, 0, 0, 0));
    send_box(mk(CMD_BOX, 1, 1, SCORE_MAX, 2000, 2000, 2100, 2300));
    drain();
  endtask

  // Threshold at both extremes
  task automatic test_score_threshold();
    set_min_score('0);
    send_box(mk(CMD_BOX, 1, 0, 0, 5, 5, 60, 60));
    send_box(mk(CMD_BOX, 0, 1, 0, 6, 5, 60, 61));
    set_min_score(SCORE_BITS'(SCORE_MAX));
    send_box(mk(CMD_BOX, 1, 0, SCORE_MAX - 1, 300, 300, 400, 400));
    send_box(mk(CMD_BOX, 0, 1, SCORE_MAX, 300, 300, 400, 400));
    send_box(mk(CMD_BOX, 1, 1, SCORE_MAX - 1, 300, 300, 400, 400));
  endtask

  // Fill the table past its size, then match and miss against a full table
  task automatic test_table_overflow();
    set_min_score(10'd600);
    rx_mode = RX_RANDOM;
    send_box(mk(CMD_CLEAR, 0, 0, 0, 0, 0, 0, 0));
    for (int k = 0; k < SLOTS + 6; k++) send_box(rand_box(k == 0, k == SLOTS + 5, 1'b1));
    for (int k = 0; k < 8; k++) send_box(rand_box(k == 0, k == 7, 1'b1));
    send_box(mk(CMD_CLEAR, 0, 0, 0, 0, 0, 0, 0));
  endtask

  // Hold off the receiver while items keep coming, then pause until drained
  task automatic test_backpressure();
    rx_mode   = RX_FREE;
    gaps_off  = 1'b1;
    hold_left = HOLD_CYCLES;
    for (int k = 0; k < 12; k++) send_box(rand_box(k == 0, k == 11, $urandom_range(0, 3) != 0));
    gaps_off = 1'b0;
    drain();
  endtask

  // Mostly well-formed frames with random content; some clears and noise
  task automatic test_random_frames(int n_items, rx_mode_t mode);
    int        start, len, dice;
    bit        brk;
    det_item_t it;
    rx_mode = mode;
    start   = n_sent;
    while (n_sent - start < n_items) begin
      dice = $urandom_range(0, 99);
      if (dice < 6) begin
        it       = rand_box(1'($urandom), 1'($urandom), 1'($urandom));
        it.cmd   = CMD_CLEAR;
        it.score = SCORE_BITS'($urandom_range(0, SCORE_MAX));
        send_box(it);
      end else if (dice < 12) begin
        len = $urandom_range(1, 3);
        for (int k = 0; k < len; k++) send_box(rand_box(k == 0, k == len - 1, 1'b0));
      end else if (dice < 18) begin
        send_box(rand_box(1'($urandom), 1'($urandom), $urandom_range(0, 3) != 0));
      end else begin
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 20) : $urandom_range(1, 6);
        brk = ($urandom_range(0, 19) == 0);
        for (int k = 0; k < len; k++)
          send_box(rand_box(k == 0, (k == len - 1) && !brk, $urandom_range(0, 9) != 0));
      end
    end
  endtask

  initial begin
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;

    test_directed_cases();
    test_score_threshold();
    test_table_overflow();
    test_backpressure();

    set_min_score(SCORE_BITS'($urandom_range(1, SCORE_MAX - 1)));
    test_random_frames(150, RX_RANDOM);
    set_min_score('0);
    test_random_frames(120, RX_PATTERN);
    set_min_score(MIN_SCORE_RST);
    test_random_frames(150, RX_FREE);
    set_min_score(SCORE_BITS'(SCORE_MAX));
    test_random_frames(40, RX_RANDOM);
    set_min_score(SCORE_BITS'($urandom_range(200, 700)));
    test_random_frames(120, RX_PATTERN);

    // let any stray result show up before the verdict
    drain();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d items, checked %0d results: %0d new vehicles, %0d full-table drops.",
             n_sent, n_got, n_new, n_full);
    $display("Thresholds 0 to %0d, receiver hold-off, random and patterned stalls; %0d mismatches.",
             SCORE_MAX, mismatches);
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

[iou_track_table_counter.f]
rtl/itc_pkg.sv
rtl/itc_datapath.sv
rtl/itc_ctrl.sv
rtl/iou_track_table_counter.sv
rtl/itc_checker.sv
dv/tb.sv
